// File: design/cglut_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cglut_pkg: shared definitions for the color gradient lookup table
// Table geometry, field widths, request modes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package cglut_pkg;

  // Table geometry.
  localparam int MAX_KEY     = 100;
  localparam int TABLE_DEPTH = MAX_KEY + 1;
  localparam int KEY_W       = $clog2(TABLE_DEPTH);

  // Field widths.
  localparam int KEY_IN_W = 32;
  localparam int COLOR_W  = 32;
  localparam int CHAN_W   = 8;
  localparam int NUM_W    = CHAN_W + KEY_W;
  localparam int STEP_W   = $clog2(CHAN_W);

  // Alpha byte of an interpolated entry.
  localparam logic [CHAN_W-1:0] FILL_ALPHA = '1;

  typedef logic [KEY_W-1:0] key_idx_t;

  // Request modes.
  typedef enum logic [1:0] {
    MODE_FIRST  = 2'd0,
    MODE_NEXT   = 2'd1,
    MODE_LOOKUP = 2'd2
  } mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;       // latch the accepted request
    logic read_en;       // read the table at the request key
    logic load_out;      // load the response register
    logic write_anchor;  // store the anchor, set up the fill
    logic load_div;      // load the channel dividers for the current entry
    logic div_step;      // one quotient bit in each divider
    logic write_fill;    // store the interpolated entry, advance the index
  } cglut_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] item_mode;
    logic       item_in_range;
    logic       fill_needed;
    logic       fill_last;
    logic       out_free;
  } cglut_status_t;

endpackage
`default_nettype wire

// File: design/cglut_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cglut_in_if: request channel of the color gradient lookup table
// Valid/ready handshake carrying mode, key and anchor color.
// ----------------------------------------------------------------------------
interface cglut_in_if;
  import cglut_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [1:0]                 mode;
  logic signed [KEY_IN_W-1:0] key;
  logic [COLOR_W-1:0]         anchor_color;

  modport source (output valid, mode, key, anchor_color, input ready);
  modport sink   (input valid, mode, key, anchor_color, output ready);
endinterface
`default_nettype wire

// File: design/cglut_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cglut_out_if: response channel of the color gradient lookup table
// Valid/ready handshake carrying the looked-up color and the found flag.
// ----------------------------------------------------------------------------
interface cglut_out_if;
  import cglut_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] color_out;
  logic               found;

  modport source (output valid, color_out, found, input ready);
  modport sink   (input valid, color_out, found, output ready);
endinterface
`default_nettype wire

// File: design/cglut_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cglut_div: restoring divider for one color channel
// Produces one quotient bit per step. The numerator is below 2^CHAN_W times
// the divisor, so CHAN_W steps give the full quotient.
// ----------------------------------------------------------------------------
module cglut_div
  import cglut_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic             step,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [KEY_W-1:0] den,
  output logic [CHAN_W-1:0]     quot
);

  logic [KEY_W-1:0]  rem;
  logic [CHAN_W-1:0] low;
  logic [KEY_W:0]    partial;
  logic              ge;

  // Trial subtraction of the divisor from the shifted remainder.
  assign partial = {rem, low[CHAN_W-1]};
  assign ge      = (partial >= {1'b0, den});

  // Remainder, pending numerator bits and quotient.
  always_ff @(posedge clk) begin
    if (load) begin
      rem  <= num[NUM_W-1:CHAN_W];
      low  <= num[CHAN_W-1:0];
      quot <= '0;
    end else if (step) begin
      rem  <= ge ? KEY_W'(partial - {1'b0, den}) : partial[KEY_W-1:0];
      low  <= {low[CHAN_W-2:0], 1'b0};
      quot <= {quot[CHAN_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: design/cglut_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cglut_ctrl: controller of the color gradient lookup table
// Sequences request decode, table lookups, anchor writes and the per-entry
// interpolation loop.
// ----------------------------------------------------------------------------
module cglut_ctrl
  import cglut_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cglut_status_t status,
  output cglut_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RESPOND,
    ST_FILL_LOAD,
    ST_FILL_DIV,
    ST_FILL_WRITE
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step_cnt;

  logic is_anchor;
  logic is_lookup;

  assign is_anchor = (status.item_mode == MODE_FIRST) || (status.item_mode == MODE_NEXT);
  assign is_lookup = (status.item_mode == MODE_LOOKUP);

  // State register and division step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          if (is_lookup) begin
            state <= ST_RESPOND;
          end else if (is_anchor && status.item_in_range && status.fill_needed) begin
            state <= ST_FILL_LOAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_RESPOND: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_FILL_LOAD: begin
          step_cnt <= '0;
          state    <= ST_FILL_DIV;
        end
        ST_FILL_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == STEP_W'(CHAN_W - 1)) begin
            state <= ST_FILL_WRITE;
          end
        end
        ST_FILL_WRITE: begin
          state <= status.fill_last ? ST_IDLE : ST_FILL_LOAD;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Commands decoded from the current state.
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd              = '0;
    cmd.capture      = (state == ST_IDLE) && in_valid;
    cmd.read_en      = (state == ST_DECODE) && is_lookup && status.item_in_range;
    cmd.write_anchor = (state == ST_DECODE) && is_anchor && status.item_in_range;
    cmd.load_out     = (state == ST_RESPOND) && status.out_free;
    cmd.load_div     = (state == ST_FILL_LOAD);
    cmd.div_step     = (state == ST_FILL_DIV);
    cmd.write_fill   = (state == ST_FILL_WRITE);
  end

endmodule
`default_nettype wire

// File: design/cglut_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cglut_datapath: table, anchor state and interpolation datapath
// Holds the color table with its per-entry valid bits, the previous anchor,
// the three channel dividers and the response register.
// ----------------------------------------------------------------------------
module cglut_datapath
  import cglut_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cglut_cmd_t                 cmd,
  output cglut_status_t                   status,
  input  wire logic [1:0]                 in_mode,
  input  wire logic signed [KEY_IN_W-1:0] in_key,
  input  wire logic [COLOR_W-1:0]         in_color,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [COLOR_W-1:0]              out_color,
  output logic                            out_found
);

  // Captured request.
  logic [1:0]         item_mode;
  key_idx_t           item_key;
  logic               item_in_range;
  logic [COLOR_W-1:0] item_color;

  // Anchor state.
  key_idx_t           prev_key;
  logic [COLOR_W-1:0] prev_color;

  // Fill state: the lower anchor and the entry being computed.
  key_idx_t           lo_key;
  logic [COLOR_W-1:0] start_color;
  key_idx_t           fill_idx;

  // Table storage.
  logic [COLOR_W-1:0]     mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [COLOR_W-1:0]     rd_data;
  logic                   rd_valid;
  logic                   wr_en;
  key_idx_t               wr_addr;
  logic [COLOR_W-1:0]     wr_data;

  logic key_in_range;
  logic [KEY_W:0] prev_key_inc;

  // Range check of the signed key; negative keys fail the upper-bit test.
  assign key_in_range = (in_key[KEY_IN_W-1:KEY_W] == '0) &&
                        (in_key[KEY_W-1:0] <= KEY_W'(MAX_KEY));

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode     <= in_mode;
      item_key      <= in_key[KEY_W-1:0];
      item_in_range <= key_in_range;
      item_color    <= in_color;
    end
  end

  // Previous anchor and fill setup.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_key   <= '0;
      prev_color <= '0;
    end else if (cmd.write_anchor) begin
      prev_key   <= item_key;
      prev_color <= item_color;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_anchor) begin
      lo_key      <= prev_key;
      start_color <= prev_color;
      fill_idx    <= prev_key + 1'b1;
    end else if (cmd.write_fill) begin
      fill_idx <= fill_idx + 1'b1;
    end
  end

  // Interpolation numerators for the current entry.
  key_idx_t         dist_lo;
  key_idx_t         dist_hi;
  key_idx_t         span;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] num_g;
  logic [NUM_W-1:0] num_b;
  logic [CHAN_W-1:0] quot_r;
  logic [CHAN_W-1:0] quot_g;
  logic [CHAN_W-1:0] quot_b;

  assign dist_lo = fill_idx - lo_key;
  assign dist_hi = item_key - fill_idx;
  assign span    = item_key - lo_key;

  assign num_r = NUM_W'(item_color[23:16]) * NUM_W'(dist_lo) +
                 NUM_W'(start_color[23:16]) * NUM_W'(dist_hi);
  assign num_g = NUM_W'(item_color[15:8]) * NUM_W'(dist_lo) +
                 NUM_W'(start_color[15:8]) * NUM_W'(dist_hi);
  assign num_b = NUM_W'(item_color[7:0]) * NUM_W'(dist_lo) +
                 NUM_W'(start_color[7:0]) * NUM_W'(dist_hi);

  cglut_div u_div_r (
    .clk  (clk),
    .load (cmd.load_div),
    .step (cmd.div_step),
    .num  (num_r),
    .den  (span),
    .quot (quot_r)
  );

  cglut_div u_div_g (
    .clk  (clk),
    .load (cmd.load_div),
    .step (cmd.div_step),
    .num  (num_g),
    .den  (span),
    .quot (quot_g)
  );

  cglut_div u_div_b (
    .clk  (clk),
    .load (cmd.load_div),
    .step (cmd.div_step),
    .num  (num_b),
    .den  (span),
    .quot (quot_b)
  );

  // Single write port shared by anchor and fill writes.
  assign wr_en   = cmd.write_anchor || cmd.write_fill;
  assign wr_addr = cmd.write_fill ? fill_idx : item_key;
  assign wr_data = cmd.write_fill ? {FILL_ALPHA, quot_r, quot_g, quot_b} : item_color;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      rd_data  <= mem[item_key];
      rd_valid <= entry_valid[item_key];
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_color <= (item_in_range && rd_valid) ? rd_data : '0;
      out_found <= item_in_range;
    end
  end

  // Status toward the controller.
  assign prev_key_inc = {1'b0, prev_key} + 1'b1;

  always_comb begin
    status               = '0;
    status.item_mode     = item_mode;
    status.item_in_range = item_in_range;
    status.fill_needed   = (item_mode == MODE_NEXT) && ({1'b0, item_key} > prev_key_inc);
    status.fill_last     = ((fill_idx + 1'b1) == item_key);
    status.out_free      = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// File: design/color_gradient_lut_interpolator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// color_gradient_lut_interpolator_core: linear color gradient lookup table
// A lookup request passes through decode and a response state before its
// response is loaded, and a new request is accepted while that response waits
// to be taken. An anchor request is decoded and written; a next anchor that
// fills entries adds, for each entry, a load of the bit-serial channel
// dividers, eight divider steps and a write of the interpolated entry.
// The table reads as all zero right after reset, with no clearing pass.
// ----------------------------------------------------------------------------
module color_gradient_lut_interpolator_core
  import cglut_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  cglut_in_if.sink   item_in,
  cglut_out_if.source result_out
);

  cglut_cmd_t    cmd;
  cglut_status_t status;

  // Sequencing of requests and the fill loop.
  cglut_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Table, anchors, dividers and response register.
  cglut_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_mode   (item_in.mode),
    .in_key    (item_in.key),
    .in_color  (item_in.anchor_color),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_color (result_out.color_out),
    .out_found (result_out.found)
  );

endmodule
`default_nettype wire
